// File: src/srpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper ramp pulse generator package
// Request and result types, configuration types and register indexes.
// ----------------------------------------------------------------------------
package srpg_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS  = 2'd2;

    localparam logic [15:0] START_DELAY_RST = 16'd4000;
    localparam logic [11:0] DELAY_STEP_RST  = 12'd7;
    localparam logic [15:0] RAMP_STEPS_RST  = 16'd530;

    typedef struct packed {
        logic        mode;
        logic        direction;
        logic [15:0] step_count;
    } srpg_in_t;

    typedef struct packed {
        logic pulse;
        logic direction_out;
        logic busy_res;
        logic done_res;
    } srpg_out_t;

    typedef struct packed {
        logic [15:0] start_delay;
        logic [11:0] delay_step;
        logic [15:0] ramp_steps;
    } srpg_cfg_t;

endpackage
`default_nettype wire

// File: src/stepper_ramp_pulse_generator.sv
`default_nettype none
// Throughput: one request per cycle, sustained while results are taken.
// The input register and the result register each take a new request as the
// next stage moves on; once both hold a request, a stalled result holds the input.
// Reset (aresetn low, synchronous) clears the move state and the valid flags of
// both registers and loads the configuration reset values.
// ----------------------------------------------------------------------------
// Stepper ramp pulse generator
// Times step pulses of a trapezoidal or triangular move from tick requests.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator
    import srpg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire srpg_in_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output srpg_out_t                  m_data
);

    srpg_cfg_t cfg;
    logic      in_valid_reg;
    srpg_in_t  in_data_reg;
    logic      core_ready;

    srpg_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    assign s_ready = !in_valid_reg || core_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    srpg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (in_valid_reg),
        .item       (in_data_reg),
        .item_ready (core_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire

// File: src/srpg_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds start delay, delay step and ramp length; writes beyond the list are
// dropped.
// ----------------------------------------------------------------------------
module srpg_cfg
    import srpg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    output srpg_cfg_t                  cfg
);

    srpg_cfg_t cfg_reg;
    srpg_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_START_DELAY: cfg_next.start_delay = cfg_wr_data;
                REG_DELAY_STEP:  cfg_next.delay_step  = cfg_wr_data[11:0];
                REG_RAMP_STEPS:  cfg_next.ramp_steps  = cfg_wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_delay <= START_DELAY_RST;
            cfg_reg.delay_step  <= DELAY_STEP_RST;
            cfg_reg.ramp_steps  <= RAMP_STEPS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: src/srpg_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Move state and result register
// Updates the move state for one request per cycle while results are taken and registers the result.
// ----------------------------------------------------------------------------
module srpg_core
    import srpg_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire srpg_cfg_t cfg,
    input  wire logic      item_valid,
    input  wire srpg_in_t  item,
    output logic           item_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output srpg_out_t      m_data
);

    logic [15:0] half_period_reg, half_period_next;
    logic [15:0] phase_timer_reg, phase_timer_next;
    logic [15:0] step_index_reg,  step_index_next;
    logic [15:0] total_steps_reg, total_steps_next;
    logic        pulse_high_reg,  pulse_high_next;
    logic        moving_reg,      moving_next;
    logic        dir_latch_reg,   dir_latch_next;
    logic        out_valid_reg;
    srpg_out_t   out_reg, out_next;

    logic        take;
    logic        start;
    logic [15:0] idx_inc;
    logic [15:0] adj_base;
    logic [15:0] adj_idx;
    logic [15:0] adj_total;
    logic [17:0] two_ramp;
    logic [15:0] half_lo;
    logic [16:0] half_hi;
    logic        go_down;
    logic        go_up;
    logic signed [17:0] adj_sum;
    logic [15:0] adj_hp;
    logic        done;

    assign item_ready = !out_valid_reg || m_ready;
    assign take       = item_valid && item_ready;
    assign start      = item.mode && !moving_reg;
    assign idx_inc    = step_index_reg + 16'd1;

    // The half-period is adjusted before each step, on start or on step advance.
    assign adj_base  = start ? cfg.start_delay : half_period_reg;
    assign adj_idx   = start ? 16'd0 : idx_inc;
    assign adj_total = start ? item.step_count : total_steps_reg;
    assign two_ramp  = {1'b0, cfg.ramp_steps, 1'b0} + 18'd1;
    assign half_lo   = {1'b0, adj_total[15:1]};
    assign half_hi   = {2'b00, adj_total[15:1]} + {16'd0, adj_total[0]};

    always_comb begin
        if ({2'b00, adj_total} > two_ramp) begin
            go_down = adj_idx < cfg.ramp_steps;
            go_up   = !go_down && (adj_idx > (adj_total - cfg.ramp_steps));
        end else begin
            go_down = adj_idx < half_lo;
            go_up   = !go_down && ({1'b0, adj_idx} > half_hi);
        end
        adj_sum = $signed({2'b00, adj_base});
        if (go_down) begin
            adj_sum = adj_sum - $signed({6'd0, cfg.delay_step});
        end else if (go_up) begin
            adj_sum = adj_sum + $signed({6'd0, cfg.delay_step});
        end
        if (adj_sum < 18'sd1) begin
            adj_hp = 16'd1;
        end else if (adj_sum > 18'sd65535) begin
            adj_hp = 16'hFFFF;
        end else begin
            adj_hp = adj_sum[15:0];
        end
    end

    always_comb begin
        half_period_next = half_period_reg;
        phase_timer_next = phase_timer_reg;
        step_index_next  = step_index_reg;
        total_steps_next = total_steps_reg;
        pulse_high_next  = pulse_high_reg;
        moving_next      = moving_reg;
        dir_latch_next   = dir_latch_reg;
        done             = 1'b0;
        if (item.mode) begin
            if (!moving_reg) begin
                dir_latch_next   = item.direction;
                total_steps_next = item.step_count;
                step_index_next  = 16'd0;
                if (item.step_count == 16'd0) begin
                    half_period_next = cfg.start_delay;
                    pulse_high_next  = 1'b0;
                    phase_timer_next = 16'd0;
                    done             = 1'b1;
                end else begin
                    moving_next      = 1'b1;
                    half_period_next = adj_hp;
                    pulse_high_next  = 1'b1;
                    phase_timer_next = adj_hp;
                end
            end
        end else if (moving_reg) begin
            if (phase_timer_reg > 16'd1) begin
                phase_timer_next = phase_timer_reg - 16'd1;
            end else if (pulse_high_reg) begin
                pulse_high_next  = 1'b0;
                phase_timer_next = half_period_reg;
            end else begin
                step_index_next = idx_inc;
                if (idx_inc >= total_steps_reg) begin
                    moving_next      = 1'b0;
                    phase_timer_next = 16'd0;
                    done             = 1'b1;
                end else begin
                    half_period_next = adj_hp;
                    pulse_high_next  = 1'b1;
                    phase_timer_next = adj_hp;
                end
            end
        end
        out_next.pulse         = pulse_high_next;
        out_next.direction_out = dir_latch_next;
        out_next.busy_res      = moving_next;
        out_next.done_res      = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= 16'd0;
            phase_timer_reg <= 16'd0;
            step_index_reg  <= 16'd0;
            total_steps_reg <= 16'd0;
            pulse_high_reg  <= 1'b0;
            moving_reg      <= 1'b0;
            dir_latch_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (take) begin
                half_period_reg <= half_period_next;
                phase_timer_reg <= phase_timer_next;
                step_index_reg  <= step_index_next;
                total_steps_reg <= total_steps_next;
                pulse_high_reg  <= pulse_high_next;
                moving_reg      <= moving_next;
                dir_latch_reg   <= dir_latch_next;
                out_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

// File: tb/tb_stepper_ramp_pulse_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stepper ramp pulse generator testbench
// Drives start and tick requests through the valid/ready input and checks every
// output level against a cycle-free model of the ramp timing, or against the table
// levels for typed rows. A short table of directed requests comes first. Random
// moves follow under four idling patterns, with configuration changes between
// them. A long move at the largest half-period ends the run.
// ----------------------------------------------------------------------------
module tb_stepper_ramp_pulse_generator;
    import srpg_pkg::*;

    localparam logic                 MODE_TICK   = 1'b0;
    localparam logic                 MODE_START  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam int                   HOLD_CYCLES = 200;
    localparam int                   PHASE_REQS  = 256;

    typedef enum logic [1:0] {ROW_REQ, ROW_TYPED, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic                 mode;
        logic                 dir;
        logic [15:0]          word;
        logic [7:0]           reps;
        srpg_out_t            want;
    } dir_row_t;

    typedef struct packed {
        logic      typed;
        srpg_out_t want;
    } level_note_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    srpg_in_t              s_data       = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    srpg_out_t             m_data;

    // Columns: kind, register, mode, direction, count or data, repeats, levels
    // (pulse, direction_out, busy_res, done_res).
    dir_row_t dir_table [15] = '{
        '{ROW_TYPED, REG_START_DELAY, MODE_TICK,  1'b1, 16'hFFFF, 8'd1,  4'b0000},
        '{ROW_TYPED, REG_START_DELAY, MODE_START, 1'b1, 16'h0000, 8'd1,  4'b0101},
        '{ROW_TYPED, REG_START_DELAY, MODE_START, 1'b0, 16'h0000, 8'd1,  4'b0001},
        '{ROW_CFG,   REG_START_DELAY, MODE_TICK,  1'b0, 16'h0000, 8'd1,  4'b0000},
        '{ROW_CFG,   REG_DELAY_STEP,  MODE_TICK,  1'b0, 16'h0FFF, 8'd1,  4'b0000},
        '{ROW_CFG,   REG_RAMP_STEPS,  MODE_TICK,  1'b0, 16'h0000, 8'd1,  4'b0000},
        '{ROW_CFG,   REG_UNUSED,      MODE_TICK,  1'b0, 16'hFFFF, 8'd1,  4'b0000},
        '{ROW_TYPED, REG_START_DELAY, MODE_START, 1'b1, 16'h0003, 8'd1,  4'b1110},
        '{ROW_REQ,   REG_START_DELAY, MODE_START, 1'b0, 16'h0007, 8'd1,  4'b0000},
        '{ROW_REQ,   REG_START_DELAY, MODE_TICK,  1'b0, 16'h5555, 8'd6,  4'b0000},
        '{ROW_CFG,   REG_START_DELAY, MODE_TICK,  1'b0, 16'h0003, 8'd1,  4'b0000},
        '{ROW_CFG,   REG_DELAY_STEP,  MODE_TICK,  1'b0, 16'h0001, 8'd1,  4'b0000},
        '{ROW_CFG,   REG_RAMP_STEPS,  MODE_TICK,  1'b0, 16'hFFFF, 8'd1,  4'b0000},
        '{ROW_REQ,   REG_START_DELAY, MODE_START, 1'b0, 16'h0005, 8'd1,  4'b0000},
        '{ROW_REQ,   REG_START_DELAY, MODE_TICK,  1'b1, 16'hAAAA, 8'd14, 4'b0000}
    };

    int sender_idle [4] = '{0, 74, 0, 8};
    int recv_stall  [4] = '{0, 0, 74, 8};
    string level_name [4] = '{"pulse", "direction_out", "busy_res", "done_res"};

    logic [15:0] cfg_start_delay;
    logic [11:0] cfg_delay_step;
    logic [15:0] cfg_ramp_steps;
    logic [15:0] motor_half;
    logic [15:0] motor_timer;
    logic [15:0] motor_index;
    logic [15:0] motor_total;
    logic        motor_pulse;
    logic        motor_moving;
    logic        motor_dir;

    level_note_t level_note_q [$];
    srpg_out_t   level_expect_q [$];
    level_note_t note;
    srpg_out_t   guess;
    srpg_out_t   want_levels;
    int          idle_pct   = 0;
    int          stall_pct  = 0;
    int          hold_reqs  = 0;
    int          hold_done  = 0;
    int          fail_count = 0;

    stepper_ramp_pulse_generator u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    always #5 aclk = ~aclk;

    // Half-period for the step numbered motor_index, then raise the pulse.
    function automatic void begin_step();
        int d;
        int i;
        int t;
        int r;
        int inc;
        d   = int'(motor_half);
        i   = int'(motor_index);
        t   = int'(motor_total);
        r   = int'(cfg_ramp_steps);
        inc = int'(cfg_delay_step);
        if (t > 2 * r + 1) begin
            if (i < r) begin
                d = d - inc;
            end else if (i > t - r) begin
                d = d + inc;
            end
        end else begin
            if (i < (t - t % 2) / 2) begin
                d = d - inc;
            end else if (i > (t + t % 2) / 2) begin
                d = d + inc;
            end
        end
        if (d < 1) begin
            d = 1;
        end
        if (d > 65535) begin
            d = 65535;
        end
        motor_half  = d[15:0];
        motor_pulse = 1'b1;
        motor_timer = motor_half;
    endfunction

    function automatic srpg_out_t predict_levels(input srpg_in_t req);
        srpg_out_t res;
        logic      fin;
        fin = 1'b0;
        if (req.mode == MODE_START) begin
            if (!motor_moving) begin
                motor_dir   = req.direction;
                motor_total = req.step_count;
                motor_index = '0;
                motor_half  = cfg_start_delay;
                motor_pulse = 1'b0;
                motor_timer = '0;
                if (req.step_count == 16'd0) begin
                    fin = 1'b1;
                end else begin
                    motor_moving = 1'b1;
                    begin_step();
                end
            end
        end else if (motor_moving) begin
            if (motor_timer > 16'd1) begin
                motor_timer = motor_timer - 16'd1;
            end else if (motor_pulse) begin
                motor_pulse = 1'b0;
                motor_timer = motor_half;
            end else begin
                motor_index = motor_index + 16'd1;
                if (motor_index >= motor_total) begin
                    motor_moving = 1'b0;
                    motor_timer  = '0;
                    fin          = 1'b1;
                end else begin
                    begin_step();
                end
            end
        end
        res.pulse         = motor_pulse;
        res.direction_out = motor_dir;
        res.busy_res      = motor_moving;
        res.done_res      = fin;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_start_delay = START_DELAY_RST;
            cfg_delay_step  = DELAY_STEP_RST;
            cfg_ramp_steps  = RAMP_STEPS_RST;
            motor_half      = '0;
            motor_timer     = '0;
            motor_index     = '0;
            motor_total     = '0;
            motor_pulse     = 1'b0;
            motor_moving    = 1'b0;
            motor_dir       = 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_START_DELAY: cfg_start_delay = cfg_wr_data;
                    REG_DELAY_STEP:  cfg_delay_step  = cfg_wr_data[11:0];
                    REG_RAMP_STEPS:  cfg_ramp_steps  = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                note  = level_note_q.pop_front();
                guess = predict_levels(s_data);
                level_expect_q.push_back(note.typed ? note.want : guess);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (level_expect_q.size() == 0) begin
                $display("%0t: result %b arrived with none expected", $time, m_data);
                fail_count++;
            end else begin
                want_levels = level_expect_q.pop_front();
                for (int f = 0; f < 4; f++) begin
                    if (m_data[3 - f] !== want_levels[3 - f]) begin
                        $display("%0t: %s expected %b, got %b", $time, level_name[f],
                                 want_levels[3 - f], m_data[3 - f]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // The receiver stalls at random and, when asked, holds off for a long stretch.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_reqs != hold_done) begin
                hold_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_req(input srpg_in_t req, input logic typed, input srpg_out_t want);
        level_note_t n;
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        n.typed = typed;
        n.want  = want;
        level_note_q.push_back(n);
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (level_expect_q.size() != 0) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    initial begin
        srpg_in_t req;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[k]) begin
            if (dir_table[k].kind == ROW_CFG) begin
                settle();
                cfg_write(dir_table[k].reg_idx, dir_table[k].word);
            end else begin
                req = {dir_table[k].mode, dir_table[k].dir, dir_table[k].word};
                repeat (dir_table[k].reps) begin
                    send_req(req, dir_table[k].kind == ROW_TYPED, dir_table[k].want);
                end
            end
        end

        for (int p = 0; p < 4; p++) begin
            settle();
            idle_pct  = sender_idle[p];
            stall_pct = recv_stall[p];
            cfg_write(REG_START_DELAY, 16'($urandom_range(0, 4)));
            cfg_write(REG_DELAY_STEP, (p == 0) ? 16'd0 : 16'($urandom_range(1, 2)));
            cfg_write(REG_RAMP_STEPS, 16'($urandom_range(0, 5)));
            if (p == 0) begin
                hold_reqs++;
            end
            repeat (PHASE_REQS) begin
                req.mode       = ($urandom_range(11) == 0) ? MODE_START : MODE_TICK;
                req.direction  = 1'($urandom_range(1));
                req.step_count = (req.mode == MODE_START) ? 16'($urandom_range(0, 16))
                                                          : 16'($urandom);
                send_req(req, 1'b0, '0);
            end
        end

        // Let the last move run out, then start the longest move at the
        // largest half-period and follow its first phase for a while.
        settle();
        while (motor_moving) begin
            req = {MODE_TICK, 1'($urandom_range(1)), 16'($urandom)};
            send_req(req, 1'b0, '0);
            settle();
        end
        cfg_write(REG_START_DELAY, 16'hFFFF);
        cfg_write(REG_RAMP_STEPS, 16'h0000);
        send_req({MODE_START, 1'b1, 16'hFFFF}, 1'b0, '0);
        repeat (40) begin
            req = {MODE_TICK, 1'($urandom_range(1)), 16'($urandom)};
            send_req(req, 1'b0, '0);
        end
        settle();
        repeat (8) @(negedge aclk);

        if (fail_count == 0 && level_expect_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timed out with %0d results outstanding", $time,
                 level_expect_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
